// File: sv/pslgd_pkg.sv
// shared types, constants and the gear decode function of the shift light and gear display
`default_nettype none
package pslgd_pkg;

	localparam int FRAME_BYTES = 8;
	localparam int BAR_LEDS    = 10;
	localparam int AUX_FIRST   = 3;
	localparam int AUX_BYTES   = 5;
	localparam int VIEW_BYTES  = AUX_FIRST + AUX_BYTES;
	localparam int CNT_W       = $clog2(FRAME_BYTES);
	localparam int THR_W       = $clog2(256 + (BAR_LEDS - 1) * 64);

	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	localparam int IDX_W       = 3;
	localparam int CFG_W       = 8;
	localparam int IN_DATA_W   = 8;
	localparam int OUT_USED_W  = BAR_LEDS + 1 + 7 + 8 + 8 * AUX_BYTES;
	localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_DATA_W - OUT_USED_W;

	localparam logic [7:0] SYNC_RST    = 8'd204;
	localparam logic [7:0] LIMITER_RST = 8'd60;
	localparam logic [7:0] START_RST   = 8'd20;
	localparam logic [5:0] STEP_RST    = 6'd4;
	localparam logic [7:0] PERIOD_RST  = 8'd240;

	localparam logic [6:0] SEG_ERROR   = 7'h6E;

	typedef enum logic [IDX_W-1:0] {
		REG_SYNC_BYTE     = 3'd0,
		REG_LIMITER_LEVEL = 3'd1,
		REG_BAR_START     = 3'd2,
		REG_BAR_STEP      = 3'd3,
		REG_BLINK_PERIOD  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] sync_byte;
		logic [7:0] limiter_level;
		logic [7:0] bar_start;
		logic [5:0] bar_step;
		logic [7:0] blink_period;
	} cfg_t;

	typedef enum logic [1:0] {
		CMD_BYTE  = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_FRAME = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                     kind;
		logic [7:0]                    rpm;
		logic [7:0]                    gear;
		logic [AUX_BYTES-1:0][7:0]     aux;
	} cmd_t;

	function automatic logic [6:0] gear_seg(input logic [7:0] code);
		logic [6:0] seg;
		case (code)
			8'd0: seg = 7'h77;
			8'd1: seg = 7'h11;
			8'd2: seg = 7'h6B;
			8'd3: seg = 7'h3B;
			8'd4: seg = 7'h1D;
			8'd5: seg = 7'h3E;
			8'd6: seg = 7'h7E;
			8'd7: seg = 7'h13;
			8'd8: seg = 7'h7F;
			8'd9: seg = 7'h3F;
			default: seg = SEG_ERROR;
		endcase
		return seg;
	endfunction

endpackage
`default_nettype wire

// File: sv/packet_shift_light_gear_display_core.sv
// top level of the frame-driven shift light and gear display
// Takes one request per clock while the queue has room: tuser 0 carries a received serial
// byte in tdata, tuser 1 is a blink timer tick. Every request gives exactly one result:
// it is written into a two-entry queue between frame assembly and the display logic,
// then into the result register. The queue lets each side stall on its own and tready
// drops only when it is full, so after a long result-side stall tready returns in the
// cycle after the results move again. tlast marks a result whose byte completed a frame.
`default_nettype none
module packet_shift_light_gear_display_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [pslgd_pkg::IDX_W-1:0]      cfg_index,
	input  wire logic [pslgd_pkg::CFG_W-1:0]      cfg_wdata,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// rx_byte
	input  wire logic [pslgd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// op
	input  wire logic                             s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// rpm_bar, limiter_blink, gear_segments, gear_value, aux_byte_3..aux_byte_7, zero pad
	output logic [pslgd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	// frame_done
	output logic                                  m_axis_tlast
);
	import pslgd_pkg::*;

	cfg_t cfg;
	cmd_t cmd_in;
	cmd_t cmd_out;
	logic push;
	logic pop;
	logic full;
	logic empty;

	pslgd_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pslgd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.push          (push),
		.cmd           (cmd_in),
		.full          (full)
	);

	pslgd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (cmd_in),
		.full   (full),
		.pop    (pop),
		.dout   (cmd_out),
		.empty  (empty)
	);

	pslgd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd_out),
		.empty         (empty),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
`default_nettype wire

// File: sv/pslgd_regs.sv
// configuration register bank
`default_nettype none
module pslgd_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [pslgd_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [pslgd_pkg::CFG_W-1:0] cfg_wdata,
	output pslgd_pkg::cfg_t                 cfg
);
	import pslgd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_byte     <= SYNC_RST;
			cfg_q.limiter_level <= LIMITER_RST;
			cfg_q.bar_start     <= START_RST;
			cfg_q.bar_step      <= STEP_RST;
			cfg_q.blink_period  <= PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SYNC_BYTE:     cfg_q.sync_byte     <= cfg_wdata[7:0];
				REG_LIMITER_LEVEL: cfg_q.limiter_level <= cfg_wdata[7:0];
				REG_BAR_START:     cfg_q.bar_start     <= cfg_wdata[7:0];
				REG_BAR_STEP:      cfg_q.bar_step      <= cfg_wdata[5:0];
				REG_BLINK_PERIOD:  cfg_q.blink_period  <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// File: sv/pslgd_front.sv
// front end: frame assembly and request classification
`default_nettype none
module pslgd_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire pslgd_pkg::cfg_t                cfg,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [pslgd_pkg::IN_DATA_W-1:0] s_axis_tdata,
	input  wire logic                           s_axis_tuser,
	output logic                                push,
	output pslgd_pkg::cmd_t                     cmd,
	input  wire logic                           full
);
	import pslgd_pkg::*;

	logic [7:0]       store_q [FRAME_BYTES];
	logic [CNT_W-1:0] byte_cnt_q;
	logic [7:0]       frame_w [FRAME_BYTES];
	logic [7:0]       view_w  [VIEW_BYTES];
	logic             accept;
	logic             is_sync;
	logic             is_last;

	assign s_axis_tready = !full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign push          = accept;
	assign is_sync       = (s_axis_tdata == cfg.sync_byte);
	assign is_last       = (byte_cnt_q == CNT_W'(FRAME_BYTES - 1));

	// incoming byte takes the last frame position
	always_comb begin
		for (int i = 0; i < FRAME_BYTES; i++) begin
			frame_w[i] = (i == FRAME_BYTES - 1) ? s_axis_tdata : store_q[i];
		end
		for (int i = 0; i < VIEW_BYTES; i++) begin
			view_w[i] = (i < FRAME_BYTES) ? frame_w[i % FRAME_BYTES] : 8'd0;
		end
	end

	always_comb begin
		cmd.kind = CMD_BYTE;
		cmd.rpm  = view_w[0];
		cmd.gear = view_w[1];
		for (int j = 0; j < AUX_BYTES; j++) begin
			cmd.aux[j] = view_w[AUX_FIRST + j];
		end
		if (s_axis_tuser) begin
			cmd.kind = CMD_TICK;
		end else if (!is_sync && is_last) begin
			cmd.kind = CMD_FRAME;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q <= '0;
		end else if (accept && !s_axis_tuser) begin
			if (is_sync || is_last) begin
				byte_cnt_q <= '0;
			end else begin
				byte_cnt_q <= byte_cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !s_axis_tuser && !is_sync) begin
			store_q[byte_cnt_q] <= s_axis_tdata;
		end
	end

endmodule
`default_nettype wire

// File: sv/pslgd_queue.sv
// short request queue between front and back end
`default_nettype none
module pslgd_queue (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire pslgd_pkg::cmd_t din,
	output logic            full,
	input  wire logic       pop,
	output pslgd_pkg::cmd_t dout,
	output logic            empty
);
	import pslgd_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QDEPTH));
	assign empty = (count_q == '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule
`default_nettype wire

// File: sv/pslgd_back.sv
// back end: led bar, limiter blink, gear segments and result register
`default_nettype none
module pslgd_back (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire pslgd_pkg::cfg_t                  cfg,
	input  wire pslgd_pkg::cmd_t                  cmd,
	input  wire logic                             empty,
	output logic                                  pop,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	output logic [pslgd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	output logic                                  m_axis_tlast
);
	import pslgd_pkg::*;

	localparam logic [BAR_LEDS-1:0] ALL_LEDS = '1;

	logic                          valid_q;
	logic [BAR_LEDS-1:0]           bar_q;
	logic                          blink_q;
	logic [7:0]                    tick_q;
	logic [6:0]                    seg_q;
	logic                          done_q;
	logic [7:0]                    gear_q;
	logic [AUX_BYTES-1:0][7:0]     aux_q;

	logic [BAR_LEDS-1:0]           bar_thermo;
	logic [THR_W-1:0]              thr;
	logic [7:0]                    tick_inc;
	logic                          is_frame;
	logic                          at_limiter;

	assign pop        = !empty && (!valid_q || m_axis_tready);
	assign is_frame   = (cmd.kind == CMD_FRAME);
	assign at_limiter = (cmd.rpm >= cfg.limiter_level);
	assign tick_inc   = tick_q + 8'd1;

	// thresholds never decrease, so per-led compares form the thermometer code
	always_comb begin
		thr = '0;
		for (int k = 0; k < BAR_LEDS; k++) begin
			thr = THR_W'(cfg.bar_start) + THR_W'(k) * THR_W'(cfg.bar_step);
			bar_thermo[k] = (THR_W'(cmd.rpm) >= thr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			bar_q   <= '0;
			blink_q <= 1'b0;
			tick_q  <= '0;
			seg_q   <= '0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				valid_q <= 1'b0;
			end
			if (pop) begin
				case (cmd.kind)
					CMD_FRAME: begin
						seg_q <= gear_seg(cmd.gear);
						if (at_limiter) begin
							if (!blink_q) begin
								bar_q   <= ALL_LEDS;
								tick_q  <= '0;
								blink_q <= 1'b1;
							end
						end else begin
							bar_q   <= bar_thermo;
							blink_q <= 1'b0;
						end
					end
					CMD_TICK: begin
						if (blink_q) begin
							if (tick_inc >= cfg.blink_period) begin
								bar_q  <= ~bar_q;
								tick_q <= '0;
							end else begin
								tick_q <= tick_inc;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			done_q <= is_frame;
			gear_q <= is_frame ? cmd.gear : 8'd0;
			aux_q  <= is_frame ? cmd.aux : '0;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tlast  = done_q;
	assign m_axis_tdata  = {OUT_PAD_W'(0), aux_q, gear_q, seg_q, blink_q, bar_q};

`ifndef SYNTHESIS
	a_limiter_entry: assert property (@(posedge clk) disable iff (!arst_n)
		pop && is_frame && at_limiter && !blink_q |=> bar_q == ALL_LEDS && blink_q)
		else $error("limiter entry did not light the whole bar");

	a_idle_payload: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !done_q |-> gear_q == 8'd0 && aux_q == '0)
		else $error("frame bytes shown without a completed frame");

	a_tick_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		pop && cmd.kind == CMD_TICK && !blink_q |=> $stable(bar_q) && $stable(tick_q))
		else $error("tick changed the bar while not blinking");
`endif

endmodule
`default_nettype wire

// File: tb/testbench.sv
// self-checking testbench of the shift light and gear display core: table, random frames, stalls
`timescale 1ns / 100ps
module testbench;
	import pslgd_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 300;

	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef struct packed {
		logic                      done;
		logic [BAR_LEDS-1:0]       bar;
		logic                      blink;
		logic [6:0]                seg;
		logic [7:0]                gear;
		logic [AUX_BYTES-1:0][7:0] aux;
	} dash_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic       typed;
		dash_t      want;
	} row_t;

	localparam dash_t QUIET = '0;
	localparam dash_t LIMIT_FRAME = '{1'b1, 10'h3FF, 1'b1, SEG_ERROR, 8'd12,
		{8'hAA, 8'h7F, 8'h80, 8'h01, 8'hFF}};

	localparam logic [6:0] DIGITS [10] = '{7'h77, 7'h11, 7'h6B, 7'h3B, 7'h1D,
		7'h3E, 7'h7E, 7'h13, 7'h7F, 7'h3F};

	localparam row_t DIRECTED [22] = '{
		'{OP_TICK, 8'h5A, 1'b1, QUIET},
		'{OP_BYTE, 8'h07, 1'b1, QUIET},
		'{OP_BYTE, SYNC_RST, 1'b1, QUIET},
		'{OP_BYTE, 8'hFF, 1'b0, QUIET},
		'{OP_BYTE, 8'h0C, 1'b0, QUIET},
		'{OP_BYTE, 8'h00, 1'b0, QUIET},
		'{OP_BYTE, 8'hFF, 1'b0, QUIET},
		'{OP_BYTE, 8'h01, 1'b0, QUIET},
		'{OP_BYTE, 8'h80, 1'b0, QUIET},
		'{OP_BYTE, 8'h7F, 1'b0, QUIET},
		'{OP_BYTE, 8'hAA, 1'b1, LIMIT_FRAME},
		'{OP_TICK, 8'h00, 1'b0, QUIET},
		'{OP_BYTE, 8'h3C, 1'b0, QUIET},
		'{OP_BYTE, 8'h09, 1'b0, QUIET},
		'{OP_BYTE, 8'h55, 1'b0, QUIET},
		'{OP_BYTE, 8'h00, 1'b0, QUIET},
		'{OP_BYTE, 8'hFE, 1'b0, QUIET},
		'{OP_BYTE, 8'h11, 1'b0, QUIET},
		'{OP_BYTE, 8'h22, 1'b0, QUIET},
		'{OP_BYTE, 8'h33, 1'b0, QUIET},
		'{OP_TICK, 8'hFF, 1'b0, QUIET},
		'{OP_TICK, 8'hA5, 1'b0, QUIET}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [IDX_W-1:0]      cfg_index;
	logic [CFG_W-1:0]      cfg_wdata;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;

	// predictor state
	cfg_t                cfg;
	logic [7:0]          frame_buf [FRAME_BYTES];
	int unsigned         frame_pos;
	logic [BAR_LEDS-1:0] leds;
	logic                blinking;
	logic [7:0]          ticks;
	logic [6:0]          digit;

	dash_t       dashboard_due [$];
	int unsigned mismatches;
	int unsigned sent;
	int unsigned idle_cycles;
	bit          src_gaps;
	bit          sink_gaps;
	bit          hold_req;
	int unsigned hold_left;

	packet_shift_light_gear_display_core DUT (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic dash_t next_dashboard(input op_t op, input logic [7:0] b);
		dash_t       r;
		int unsigned lit;
		r = '0;
		if (op == OP_BYTE) begin
			if (b == cfg.sync_byte) begin
				frame_pos = 0;
			end else begin
				frame_buf[frame_pos] = b;
				frame_pos++;
				if (frame_pos == FRAME_BYTES) begin
					frame_pos = 0;
					r.done = 1'b1;
					if (frame_buf[0] >= cfg.limiter_level) begin
						if (!blinking) begin
							leds = '1;
							ticks = '0;
							blinking = 1'b1;
						end
					end else begin
						blinking = 1'b0;
						lit = 0;
						for (int k = 0; k < BAR_LEDS; k++)
							if (int'(frame_buf[0]) >= int'(cfg.bar_start) + k * int'(cfg.bar_step))
								lit = k + 1;
						leds = BAR_LEDS'((1 << lit) - 1);
					end
					digit = (frame_buf[1] < 10) ? DIGITS[frame_buf[1]] : SEG_ERROR;
					r.gear = frame_buf[1];
					for (int j = 0; j < AUX_BYTES; j++)
						r.aux[j] = frame_buf[AUX_FIRST + j];
				end
			end
		end else if (blinking) begin
			ticks = ticks + 8'd1;
			if (ticks >= cfg.blink_period) begin
				leds = ~leds;
				ticks = '0;
			end
		end
		r.bar = leds;
		r.blink = blinking;
		r.seg = digit;
		return r;
	endfunction

	task automatic flag_error(input string msg);
		mismatches++;
		$display("mismatch %0d at %0t: %s", mismatches, $realtime, msg);
	endtask

	task automatic compare_field(input string name, input logic [9:0] got, input logic [9:0] want);
		if (got !== want)
			flag_error($sformatf("%s got %h expected %h", name, got, want));
	endtask

	task automatic check_result();
		dash_t got;
		dash_t want;
		got = '{m_axis_tlast, m_axis_tdata[9:0], m_axis_tdata[10], m_axis_tdata[17:11],
			m_axis_tdata[25:18], m_axis_tdata[65:26]};
		if (dashboard_due.size() == 0) begin
			flag_error("result with no request pending");
			return;
		end
		want = dashboard_due.pop_front();
		compare_field("frame_done", 10'(got.done), 10'(want.done));
		compare_field("rpm_bar", got.bar, want.bar);
		compare_field("limiter_blink", 10'(got.blink), 10'(want.blink));
		compare_field("gear_segments", 10'(got.seg), 10'(want.seg));
		compare_field("gear_value", 10'(got.gear), 10'(want.gear));
		for (int j = 0; j < AUX_BYTES; j++)
			compare_field($sformatf("aux_byte_%0d", AUX_FIRST + j), 10'(got.aux[j]),
				10'(want.aux[j]));
	endtask

	task automatic send_req(input op_t op, input logic [7:0] b, input logic typed = 1'b0,
		input dash_t want = '0);
		dash_t predicted;
		if (src_gaps && $urandom_range(99) < 20) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= op;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predicted = next_dashboard(op, b);
		dashboard_due.push_back(typed ? want : predicted);
		sent++;
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (dashboard_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [7:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		case (idx)
			REG_SYNC_BYTE:     cfg.sync_byte = v;
			REG_LIMITER_LEVEL: cfg.limiter_level = v;
			REG_BAR_START:     cfg.bar_start = v;
			REG_BAR_STEP:      cfg.bar_step = v[5:0];
			REG_BLINK_PERIOD:  cfg.blink_period = v;
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [7:0] sync_v, input logic [7:0] lim_v,
		input logic [7:0] start_v, input logic [5:0] step_v, input logic [7:0] period_v);
		wait_idle();
		write_reg(REG_SYNC_BYTE, sync_v);
		write_reg(REG_LIMITER_LEVEL, lim_v);
		write_reg(REG_BAR_START, start_v);
		write_reg(REG_BAR_STEP, {2'b00, step_v});
		write_reg(REG_BLINK_PERIOD, period_v);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] pick_rpm();
		int v;
		case ($urandom_range(3))
			0: v = $urandom_range(255);
			1: v = int'(cfg.limiter_level) - 1 + int'($urandom_range(2));
			default: v = int'(cfg.bar_start) + int'($urandom_range(BAR_LEDS - 1)) *
				int'(cfg.bar_step) - 1 + int'($urandom_range(1));
		endcase
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return 8'(v);
	endfunction

	function automatic logic [7:0] skip_sync(input logic [7:0] v);
		return (v == cfg.sync_byte) ? v + 8'd1 : v;
	endfunction

	task automatic tick_burst(input int unsigned n);
		repeat (n) send_req(OP_TICK, 8'($urandom_range(255)));
	endtask

	task automatic send_frame(input int unsigned len);
		logic [7:0] b;
		if ($urandom_range(9) != 0)
			send_req(OP_BYTE, cfg.sync_byte);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 15)
				tick_burst($urandom_range(1, 4));
			case (i)
				0: b = pick_rpm();
				1: b = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(11));
				default: b = 8'($urandom_range(255));
			endcase
			send_req(OP_BYTE, skip_sync(b));
		end
	endtask

	task automatic run_random(input int unsigned n);
		int unsigned target;
		int unsigned pick;
		target = sent + n;
		while (sent < target) begin
			pick = $urandom_range(99);
			if (pick < 65)
				send_frame(FRAME_BYTES);
			else if (pick < 80)
				tick_burst($urandom_range(1, 12));
			else if (pick < 92)
				send_frame($urandom_range(1, FRAME_BYTES - 1));
			else
				send_req(OP_BYTE, 8'($urandom_range(255)));
		end
	endtask

	// result side: check, then choose tready for the next edge
	initial begin
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				check_result();
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= !(sink_gaps && $urandom_range(99) < 33);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= REG_SYNC_BYTE;
		cfg_wdata     <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= 1'b0;
		idle_cycles   = 0;
		mismatches    = 0;
		sent          = 0;
		hold_req      = 1'b0;
		hold_left     = 0;
		src_gaps      = 1'b1;
		sink_gaps     = 1'b1;
		cfg           = '{SYNC_RST, LIMITER_RST, START_RST, STEP_RST, PERIOD_RST};
		frame_pos     = 0;
		leds          = '0;
		blinking      = 1'b0;
		ticks         = '0;
		digit         = '0;
		foreach (frame_buf[i])
			frame_buf[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i])
			send_req(DIRECTED[i].op, DIRECTED[i].data, DIRECTED[i].typed, DIRECTED[i].want);

		run_random(170);
		apply_settings(8'hFF, 8'd255, 8'd0, 6'd1, 8'd1);
		run_random(170);
		apply_settings(8'h00, 8'd0, 8'd255, 6'd63, 8'd255);
		run_random(130);
		// zero step and zero period, with no idling on either side
		apply_settings(8'h55, 8'd100, 8'd10, 6'd0, 8'd0);
		src_gaps = 1'b0;
		sink_gaps = 1'b0;
		run_random(170);
		src_gaps = 1'b1;
		sink_gaps = 1'b1;
		// result side holds off while requests keep coming
		apply_settings(8'hCC, 8'd200, 8'd30, 6'd20, 8'd3);
		hold_req = 1'b1;
		run_random(170);
		apply_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 6'($urandom_range(63)), 8'($urandom_range(255)));
		run_random(170);

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
